// ===== hw/rtl/sctr_pkg.sv =====
// shared types and constants for the simon 64/96 counter-mode keystream unit
package sctr_pkg;

	// number of cipher rounds for simon 64/96
	localparam int unsigned RoundsDefault = 42;

	// key schedule constant and z sequence, z taken from its lsb up
	localparam logic [31:0] SchedC = 32'hffff_fffc;
	localparam logic [63:0] SchedZ = 64'h7369_f885_192c_0ef5;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KEY0       = 3'd0,
		REG_KEY1       = 3'd1,
		REG_KEY2       = 3'd2,
		REG_NONCE_LOW  = 3'd3,
		REG_NONCE_HIGH = 3'd4
	} reg_idx_t;

	// input transaction payload
	typedef struct packed {
		logic [31:0] data_lo;
		logic [31:0] data_hi;
		logic [3:0]  byte_count;
		logic        restart;
	} in_item_t;

	// output transaction payload
	typedef struct packed {
		logic [31:0] out_lo;
		logic [31:0] out_hi;
	} out_item_t;

	// cipher block halves
	typedef struct packed {
		logic [31:0] hi;
		logic [31:0] lo;
	} blk_t;

endpackage

// ===== hw/rtl/sctr_round.sv =====
// one simon 64/96 round together with one key schedule step
module sctr_round #(
	parameter int unsigned CntW = 6
) (
	input  logic [CntW-1:0] round_idx,
	input  sctr_pkg::blk_t  blk,
	input  logic [31:0]     k0,
	input  logic [31:0]     k2,
	output sctr_pkg::blk_t  blk_next,
	output logic [31:0]     k_next
);
	import sctr_pkg::*;

	logic [5:0]  z_idx;
	logic        z_bit;
	logic [31:0] f_out;

	// round function f(x) = (x<<<1 & x<<<8) ^ x<<<2
	function automatic logic [31:0] mix(input logic [31:0] v);
		return ({v[30:0], v[31]} & {v[23:0], v[31:24]}) ^ {v[29:0], v[31:30]};
	endfunction

	// feistel round
	assign f_out        = mix(blk.hi);
	assign blk_next.hi  = blk.lo ^ f_out ^ k0;
	assign blk_next.lo  = blk.hi;

	// next round key: uses the key three rounds back and the newest one
	assign z_idx  = 6'(round_idx);
	assign z_bit  = SchedZ[z_idx];
	assign k_next = SchedC ^ {31'd0, z_bit} ^ k0
		^ {k2[2:0], k2[31:3]} ^ {k2[3:0], k2[31:4]};

endmodule

// ===== hw/rtl/simon64_96_ctr_keystream_xor_unit.sv =====
// top level of the simon 64/96 counter-mode keystream xor unit
//
// Each input transaction is one 64-bit data block. The unit builds the counter
// block {nonce_high, nonce_low + block index}, runs it through 42 simon rounds
// and xors the data with the result, zeroing bytes past byte_count. A single
// round/key-schedule unit is reused once per cycle, so a block occupies the
// unit from acceptance until its result is loaded into the output register,
// and no new block is taken until then. The output register lets the next
// block be accepted while a result waits. Round keys are expanded on the fly
// from the key registers, so the key and nonce registers may be written on
// any idle cycle; cfg_ready is always high.
module simon64_96_ctr_keystream_xor_unit #(
	parameter int unsigned ROUNDS = sctr_pkg::RoundsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sctr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sctr_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import sctr_pkg::*;

	localparam int unsigned CntW      = $clog2(ROUNDS);
	localparam logic [CntW-1:0] LastRound = CntW'(ROUNDS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] round_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic [31:0] key0_q, key1_q, key2_q, nonce_low_q, nonce_high_q;
	logic [31:0] block_index_q;

	blk_t        blk_q;
	logic [31:0] k0_q, k1_q, k2_q;
	logic [31:0] dlo_q, dhi_q;
	logic [63:0] mask_q;

	blk_t        blk_next;
	logic [31:0] k_next;
	logic [31:0] idx_cur;
	logic        in_acc;
	logic        out_free;
	logic        last_round;
	logic        load_out;
	out_item_t   result;

	// byte mask for a count, counts above eight act as eight
	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[b*8 +: 8] = {8{4'(b) < cnt}};
		end
		return m;
	endfunction

	// shared round and key schedule unit
	sctr_round #(
		.CntW(CntW)
	) u_round (
		.round_idx(round_q),
		.blk      (blk_q),
		.k0       (k0_q),
		.k2       (k2_q),
		.blk_next (blk_next),
		.k_next   (k_next)
	);

	// handshake and sequencing terms
	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign last_round = (state_q == ST_RUN) && (round_q == LastRound);
	assign load_out   = (last_round || (state_q == ST_HOLD)) && out_free;
	assign idx_cur    = in_data.restart ? 32'd0 : block_index_q;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// final round is folded into the xor with keystream, masked to the valid bytes
	assign result.out_lo = (dlo_q ^ blk_next.lo) & mask_q[31:0];
	assign result.out_hi = (dhi_q ^ blk_next.hi) & mask_q[63:32];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q       <= '0;
			key1_q       <= '0;
			key2_q       <= '0;
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY0:       key0_q       <= cfg_data;
				REG_KEY1:       key1_q       <= cfg_data;
				REG_KEY2:       key2_q       <= cfg_data;
				REG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				REG_NONCE_HIGH: nonce_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, block index and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_q       <= '0;
			block_index_q <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (load_out) begin
				out_q       <= result;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						block_index_q <= idx_cur + 32'd1;
						round_q       <= '0;
						state_q       <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_round) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cipher datapath: load counter block and keys, then one round per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_q.hi <= nonce_high_q;
			blk_q.lo <= nonce_low_q + idx_cur;
			k0_q     <= key0_q;
			k1_q     <= key1_q;
			k2_q     <= key2_q;
			dlo_q    <= in_data.data_lo;
			dhi_q    <= in_data.data_hi;
			mask_q   <= byte_mask(in_data.byte_count);
		end else if (state_q == ST_RUN) begin
			if (!last_round) begin
				blk_q <= blk_next;
				k0_q  <= k1_q;
				k1_q  <= k2_q;
				k2_q  <= k_next;
			end
		end
	end

	// accepted block starts at round zero
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (round_q == '0))
		else $error("accepted block did not start at round zero");

	// round counter advances by one while the cipher runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (round_q != LastRound)
		|=> (state_q == ST_RUN) && (round_q == $past(round_q) + 1'b1))
		else $error("round counter skipped");

	// a new result appears only after the last round or from hold
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(last_round) || $past(state_q == ST_HOLD))
		else $error("result produced before the rounds finished");

	// no input is taken while a block is in the cipher
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> !$past(in_acc) || (round_q == '0))
		else $error("input accepted during a running block");

endmodule
